[hdl/ppl_pkg.sv]
// Shared types and constants for the particle pool lifetime block.
package ppl_pkg;

    // Pool geometry
    localparam int POOL_SIZE = 32;
    localparam int IDX_W     = $clog2(POOL_SIZE);
    localparam int STEP_W    = $clog2(POOL_SIZE + 1);
    localparam int SLOT_W    = 6;
    localparam int POS_W     = 16;
    localparam int LIFE_W    = 16;

    // Command and result kinds
    localparam logic KIND_SPAWN = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Command beat
    typedef struct packed {
        logic                    kind;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [LIFE_W-1:0]       life_ticks;
    } cmd_t;

    // Result beat
    typedef struct packed {
        logic                    result_kind;
        logic [SLOT_W-1:0]       slot;
        logic                    spawn_ok;
        logic                    drawn;
        logic signed [POS_W-1:0] out_x;
        logic signed [POS_W-1:0] out_y;
        logic                    last;
    } rsp_t;

endpackage

[hdl/particle_pool_lifetime.sv]
// Particle pool with LIFO free list, doubly linked alive list and lifetime walk.
//
// A spawn is taken whenever busy is low and answers with one result beat in the
// next cycle; busy stays low, so spawns can follow each other every cycle. A tick
// raises busy until the walk over the alive slots (at most 32) is done: the walker
// visits one alive slot per cycle, decrementing its life or freeing it through a
// single shared decrement/compare and unlink path. Draw results leave at most one
// per cycle and are held in a register so the final one can carry last; a tick
// that draws nothing gives one empty result. rsp_valid marks a beat for exactly one
// cycle and cannot be held off, so the receiver must take every beat as it comes.
module particle_pool_lifetime (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ppl_pkg::cmd_t       cmd,
    output logic                rsp_valid,
    output ppl_pkg::rsp_t       rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    // Slot storage
    logic [ppl_pkg::LIFE_W-1:0]       life_reg      [ppl_pkg::POOL_SIZE];
    logic signed [ppl_pkg::POS_W-1:0] pos_x_reg     [ppl_pkg::POOL_SIZE];
    logic signed [ppl_pkg::POS_W-1:0] pos_y_reg     [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::IDX_W-1:0]        next_live_reg [ppl_pkg::POOL_SIZE];
    logic                             next_ok_reg   [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::IDX_W-1:0]        prev_live_reg [ppl_pkg::POOL_SIZE];
    logic                             prev_ok_reg   [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::IDX_W-1:0]        next_free_reg [ppl_pkg::POOL_SIZE];
    logic                             free_ok_reg   [ppl_pkg::POOL_SIZE];

    // Control state
    logic                       state_reg, state_next;
    logic [ppl_pkg::IDX_W-1:0]  free_head_reg, free_head_next;
    logic                       free_head_ok_reg, free_head_ok_next;
    logic [ppl_pkg::IDX_W-1:0]  live_head_reg, live_head_next;
    logic                       live_head_ok_reg, live_head_ok_next;
    logic [ppl_pkg::IDX_W-1:0]  cur_reg, cur_next;
    logic                       cur_ok_reg, cur_ok_next;
    logic [ppl_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [ppl_pkg::IDX_W-1:0]  pend_slot_reg, pend_slot_next;
    logic signed [ppl_pkg::POS_W-1:0] pend_x_reg, pend_x_next;
    logic signed [ppl_pkg::POS_W-1:0] pend_y_reg, pend_y_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    ppl_pkg::rsp_t              rsp_reg, rsp_next;

    // Datapath taps
    logic                       accept;
    logic                       spawn_go;
    logic                       walk_step;
    logic                       cur_dead;
    logic                       free_go;
    logic                       draw_go;
    logic [ppl_pkg::IDX_W-1:0]  cur_prev;
    logic                       cur_prev_ok;
    logic [ppl_pkg::IDX_W-1:0]  cur_nxt;
    logic                       cur_nxt_ok;
    logic [ppl_pkg::LIFE_W-1:0] cur_life;

    assign busy      = (state_reg == ST_WALK);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign accept    = start && !busy;
    assign spawn_go  = accept && (cmd.kind == ppl_pkg::KIND_SPAWN) && free_head_ok_reg;
    assign walk_step = (state_reg == ST_WALK) && cur_ok_reg
                       && (steps_reg < ppl_pkg::STEP_W'(ppl_pkg::POOL_SIZE));

    // Shared lookup and compare on the walked slot
    assign cur_life    = life_reg[cur_reg];
    assign cur_prev    = prev_live_reg[cur_reg];
    assign cur_prev_ok = prev_ok_reg[cur_reg];
    assign cur_nxt     = next_live_reg[cur_reg];
    assign cur_nxt_ok  = next_ok_reg[cur_reg];
    assign cur_dead    = (cur_life == '0);
    assign free_go     = walk_step && cur_dead;
    assign draw_go     = walk_step && !cur_dead;

    // Sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        free_head_next    = free_head_reg;
        free_head_ok_next = free_head_ok_reg;
        live_head_next    = live_head_reg;
        live_head_ok_next = live_head_ok_reg;
        cur_next          = cur_reg;
        cur_ok_next       = cur_ok_reg;
        steps_next        = steps_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        pend_x_next       = pend_x_reg;
        pend_y_next       = pend_y_reg;
        rsp_valid_next    = 1'b0;
        rsp_next          = rsp_reg;

        if (accept && (cmd.kind == ppl_pkg::KIND_SPAWN))
        begin
            rsp_valid_next       = 1'b1;
            rsp_next.result_kind = ppl_pkg::KIND_SPAWN;
            rsp_next.drawn       = 1'b0;
            rsp_next.out_x       = '0;
            rsp_next.out_y       = '0;
            rsp_next.last        = 1'b1;
            if (free_head_ok_reg)
            begin
                rsp_next.slot     = ppl_pkg::SLOT_W'(free_head_reg);
                rsp_next.spawn_ok = 1'b1;
                free_head_next    = next_free_reg[free_head_reg];
                free_head_ok_next = free_ok_reg[free_head_reg];
                live_head_next    = free_head_reg;
                live_head_ok_next = 1'b1;
            end
            else
            begin
                rsp_next.slot     = '0;
                rsp_next.spawn_ok = 1'b0;
            end
        end
        else if (accept)
        begin
            state_next      = ST_WALK;
            cur_next        = live_head_reg;
            cur_ok_next     = live_head_ok_reg;
            steps_next      = '0;
            pend_valid_next = 1'b0;
        end
        else if (state_reg == ST_WALK)
        begin
            if (walk_step)
            begin
                steps_next  = steps_reg + 1'b1;
                cur_next    = cur_nxt;
                cur_ok_next = cur_nxt_ok;
                if (cur_dead)
                begin
                    // unlink from alive list, push on free list
                    if (!cur_prev_ok)
                    begin
                        live_head_next    = cur_nxt;
                        live_head_ok_next = cur_nxt_ok;
                    end
                    free_head_next    = cur_reg;
                    free_head_ok_next = 1'b1;
                end
                else
                begin
                    // release the held draw, hold this one
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next       = 1'b1;
                        rsp_next.result_kind = ppl_pkg::KIND_TICK;
                        rsp_next.slot        = ppl_pkg::SLOT_W'(pend_slot_reg);
                        rsp_next.spawn_ok    = 1'b0;
                        rsp_next.drawn       = 1'b1;
                        rsp_next.out_x       = pend_x_reg;
                        rsp_next.out_y       = pend_y_reg;
                        rsp_next.last        = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_slot_next  = cur_reg;
                    pend_x_next     = pos_x_reg[cur_reg];
                    pend_y_next     = pos_y_reg[cur_reg];
                end
            end
            else
            begin
                // walk done: final beat
                state_next           = ST_IDLE;
                rsp_valid_next       = 1'b1;
                rsp_next.result_kind = ppl_pkg::KIND_TICK;
                rsp_next.spawn_ok    = 1'b0;
                rsp_next.last        = 1'b1;
                if (pend_valid_reg)
                begin
                    rsp_next.slot  = ppl_pkg::SLOT_W'(pend_slot_reg);
                    rsp_next.drawn = 1'b1;
                    rsp_next.out_x = pend_x_reg;
                    rsp_next.out_y = pend_y_reg;
                end
                else
                begin
                    rsp_next.slot  = '0;
                    rsp_next.drawn = 1'b0;
                    rsp_next.out_x = '0;
                    rsp_next.out_y = '0;
                end
                pend_valid_next = 1'b0;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            free_head_reg    <= '0;
            free_head_ok_reg <= 1'b1;
            live_head_reg    <= '0;
            live_head_ok_reg <= 1'b0;
            cur_reg          <= '0;
            cur_ok_reg       <= 1'b0;
            steps_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            free_head_reg    <= free_head_next;
            free_head_ok_reg <= free_head_ok_next;
            live_head_reg    <= live_head_next;
            live_head_ok_reg <= live_head_ok_next;
            cur_reg          <= cur_next;
            cur_ok_reg       <= cur_ok_next;
            steps_reg        <= steps_next;
            pend_valid_reg   <= pend_valid_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_slot_reg <= pend_slot_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        rsp_reg       <= rsp_next;
    end

    // Free list links, reset to index order
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppl_pkg::POOL_SIZE; i++)
            begin
                next_free_reg[i] <= ppl_pkg::IDX_W'((i + 1) % ppl_pkg::POOL_SIZE);
                free_ok_reg[i]   <= (i + 1 < ppl_pkg::POOL_SIZE);
            end
        end
        else if (free_go)
        begin
            next_free_reg[cur_reg] <= free_head_reg;
            free_ok_reg[cur_reg]   <= free_head_ok_reg;
        end
    end

    // Slot contents and alive links
    always_ff @(posedge clk)
    begin
        if (spawn_go)
        begin
            life_reg[free_head_reg]      <= cmd.life_ticks;
            pos_x_reg[free_head_reg]     <= cmd.pos_x;
            pos_y_reg[free_head_reg]     <= cmd.pos_y;
            next_live_reg[free_head_reg] <= live_head_reg;
            next_ok_reg[free_head_reg]   <= live_head_ok_reg;
            prev_live_reg[free_head_reg] <= '0;
            prev_ok_reg[free_head_reg]   <= 1'b0;
            if (live_head_ok_reg)
            begin
                prev_live_reg[live_head_reg] <= free_head_reg;
                prev_ok_reg[live_head_reg]   <= 1'b1;
            end
        end
        if (draw_go)
        begin
            life_reg[cur_reg] <= cur_life - 1'b1;
        end
        if (free_go)
        begin
            life_reg[cur_reg] <= '0;
            if (cur_prev_ok)
            begin
                next_live_reg[cur_prev] <= cur_nxt;
                next_ok_reg[cur_prev]   <= cur_nxt_ok;
            end
            if (cur_nxt_ok)
            begin
                prev_live_reg[cur_nxt] <= cur_prev;
                prev_ok_reg[cur_nxt]   <= cur_prev_ok;
            end
        end
    end

    // Checks
    a_spawn_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.kind == ppl_pkg::KIND_SPAWN)
        |=> rsp_valid && (rsp.result_kind == ppl_pkg::KIND_SPAWN) && rsp.last)
        else $error("spawn without answer beat");

    a_tick_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.result_kind == ppl_pkg::KIND_TICK) |-> !rsp.spawn_ok)
        else $error("tick result with spawn_ok set");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (steps_reg <= ppl_pkg::STEP_W'(ppl_pkg::POOL_SIZE)))
        else $error("walk past pool size");

    a_walk_ends_last: assert property (@(posedge clk) disable iff (!rst_n)
        busy && !walk_step |=> !busy && rsp_valid && rsp.last)
        else $error("walk end without final beat");

    a_pend_only_walk: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> busy)
        else $error("held draw outside a walk");

endmodule

[dv/particle_pool_checker.sv]
// Checker for the particle pool: mirrors the free and alive lists and scores every result beat.
`timescale 1ns / 1ps

module particle_pool_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  ppl_pkg::cmd_t cmd,
    input  logic          rsp_valid,
    input  ppl_pkg::rsp_t rsp,
    output int            fail_count,
    output int            pending
);

    // Mirror of the pool state
    logic [ppl_pkg::LIFE_W-1:0] life_left    [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::POS_W-1:0]  slot_px      [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::POS_W-1:0]  slot_py      [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::IDX_W-1:0]  live_next    [ppl_pkg::POOL_SIZE];
    logic                       live_next_ok [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::IDX_W-1:0]  live_prev    [ppl_pkg::POOL_SIZE];
    logic                       live_prev_ok [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::IDX_W-1:0]  free_next    [ppl_pkg::POOL_SIZE];
    logic                       free_next_ok [ppl_pkg::POOL_SIZE];
    logic [ppl_pkg::IDX_W-1:0]  live_head;
    logic                       live_head_ok;
    logic [ppl_pkg::IDX_W-1:0]  free_head;
    logic                       free_head_ok;

    // Result beats still owed by the block, oldest first
    ppl_pkg::rsp_t owed_beats[$];

    function automatic ppl_pkg::rsp_t make_beat(logic kind,
                                                logic [ppl_pkg::SLOT_W-1:0] slot,
                                                logic ok, logic drawn,
                                                logic [ppl_pkg::POS_W-1:0] x,
                                                logic [ppl_pkg::POS_W-1:0] y,
                                                logic last);
        ppl_pkg::rsp_t b;
        b.result_kind = kind;
        b.slot        = slot;
        b.spawn_ok    = ok;
        b.drawn       = drawn;
        b.out_x       = x;
        b.out_y       = y;
        b.last        = last;
        return b;
    endfunction

    function automatic string beat_text(ppl_pkg::rsp_t b);
        return $sformatf("kind=%0d slot=%0d ok=%0d drawn=%0d x=%0d y=%0d last=%0d",
                         b.result_kind, b.slot, b.spawn_ok, b.drawn, b.out_x, b.out_y,
                         b.last);
    endfunction

    // Everything free in index order, alive list empty
    task automatic pool_clear();
        for (int i = 0; i < ppl_pkg::POOL_SIZE; i++)
        begin
            life_left[i]    = '0;
            slot_px[i]      = '0;
            slot_py[i]      = '0;
            live_next[i]    = '0;
            live_next_ok[i] = 1'b0;
            live_prev[i]    = '0;
            live_prev_ok[i] = 1'b0;
            free_next[i]    = ppl_pkg::IDX_W'(i + 1);
            free_next_ok[i] = (i + 1 < ppl_pkg::POOL_SIZE);
        end
        live_head    = '0;
        live_head_ok = 1'b0;
        free_head    = '0;
        free_head_ok = 1'b1;
    endtask

    // Pop the free head, link it at the alive front
    task automatic pool_spawn(ppl_pkg::cmd_t c);
        logic [ppl_pkg::IDX_W-1:0] s;
        if (!free_head_ok)
        begin
            owed_beats.push_back(make_beat(ppl_pkg::KIND_SPAWN, '0, 1'b0, 1'b0, '0, '0,
                                           1'b1));
        end
        else
        begin
            s               = free_head;
            free_head       = free_next[s];
            free_head_ok    = free_next_ok[s];
            life_left[s]    = c.life_ticks;
            slot_px[s]      = c.pos_x;
            slot_py[s]      = c.pos_y;
            live_next[s]    = live_head;
            live_next_ok[s] = live_head_ok;
            live_prev[s]    = '0;
            live_prev_ok[s] = 1'b0;
            if (live_head_ok)
            begin
                live_prev[live_head]    = s;
                live_prev_ok[live_head] = 1'b1;
            end
            live_head    = s;
            live_head_ok = 1'b1;
            owed_beats.push_back(make_beat(ppl_pkg::KIND_SPAWN, ppl_pkg::SLOT_W'(s), 1'b1,
                                           1'b0, '0, '0, 1'b1));
        end
    endtask

    // Unlink an expired slot and push it on the free list
    task automatic pool_release(logic [ppl_pkg::IDX_W-1:0] s);
        if (live_prev_ok[s])
        begin
            live_next[live_prev[s]]    = live_next[s];
            live_next_ok[live_prev[s]] = live_next_ok[s];
        end
        else
        begin
            live_head    = live_next[s];
            live_head_ok = live_next_ok[s];
        end
        if (live_next_ok[s])
        begin
            live_prev[live_next[s]]    = live_prev[s];
            live_prev_ok[live_next[s]] = live_prev_ok[s];
        end
        life_left[s]    = '0;
        free_next[s]    = free_head;
        free_next_ok[s] = free_head_ok;
        free_head       = s;
        free_head_ok    = 1'b1;
    endtask

    // Walk the alive list newest first; last flag goes on the final draw, or on an empty beat
    task automatic pool_tick();
        logic [ppl_pkg::IDX_W-1:0] cur;
        logic [ppl_pkg::IDX_W-1:0] nxt;
        logic                      cur_ok;
        logic                      nxt_ok;
        int                        steps;
        int                        draws;
        ppl_pkg::rsp_t             tail;
        cur    = live_head;
        cur_ok = live_head_ok;
        steps  = 0;
        draws  = 0;
        while (cur_ok && steps < ppl_pkg::POOL_SIZE)
        begin
            nxt    = live_next[cur];
            nxt_ok = live_next_ok[cur];
            steps++;
            if (life_left[cur] == '0)
            begin
                pool_release(cur);
            end
            else
            begin
                life_left[cur] = life_left[cur] - 1'b1;
                owed_beats.push_back(make_beat(ppl_pkg::KIND_TICK, ppl_pkg::SLOT_W'(cur),
                                               1'b0, 1'b1, slot_px[cur], slot_py[cur],
                                               1'b0));
                draws++;
            end
            cur    = nxt;
            cur_ok = nxt_ok;
        end
        if (draws == 0)
        begin
            owed_beats.push_back(make_beat(ppl_pkg::KIND_TICK, '0, 1'b0, 1'b0, '0, '0,
                                           1'b1));
        end
        else
        begin
            tail      = owed_beats.pop_back();
            tail.last = 1'b1;
            owed_beats.push_back(tail);
        end
    endtask

    // Score one result beat against the oldest owed one
    task automatic check_beat(ppl_pkg::rsp_t got);
        ppl_pkg::rsp_t want;
        logic          bad;
        if (owed_beats.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] result beat with nothing owed: %s", $time, beat_text(got));
        end
        else
        begin
            want = owed_beats.pop_front();
            bad  = (got.result_kind !== want.result_kind) ||
                   (got.slot        !== want.slot)        ||
                   (got.spawn_ok    !== want.spawn_ok)    ||
                   (got.drawn       !== want.drawn)       ||
                   (got.out_x       !== want.out_x)       ||
                   (got.out_y       !== want.out_y)       ||
                   (got.last        !== want.last);
            if (bad)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("[%0t] result beat mismatch", $time);
                    $display("    expected %s", beat_text(want));
                    $display("    actual   %s", beat_text(got));
                end
            end
        end
    endtask

    // Accept first, then score, so a beat never races its own prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_clear();
            owed_beats.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (cmd.kind == ppl_pkg::KIND_SPAWN)
                    pool_spawn(cmd);
                else
                    pool_tick();
            end
            if (rsp_valid)
                check_beat(rsp);
            pending = owed_beats.size();
        end
    end

endmodule

[dv/particle_pool_lifetime_tb.sv]
// Testbench top for the particle pool: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module particle_pool_lifetime_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    ppl_pkg::cmd_t cmd;
    logic          rsp_valid;
    ppl_pkg::rsp_t rsp;

    int fail_count;
    int pending;
    int cycles     = 0;
    int cmds_taken = 0;
    int idle_pct   = 0;

    particle_pool_lifetime dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

    particle_pool_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic ppl_pkg::cmd_t make_cmd(logic kind, int x, int y, int life);
        ppl_pkg::cmd_t c;
        c.kind       = kind;
        c.pos_x      = ppl_pkg::POS_W'(x);
        c.pos_y      = ppl_pkg::POS_W'(y);
        c.life_ticks = ppl_pkg::LIFE_W'(life);
        return c;
    endfunction

    // Mostly short lives so slots recycle; now and then any 16-bit value
    function automatic int short_life();
        if ($urandom_range(24) == 0)
            return int'($urandom_range(65535));
        return int'($urandom_range(4));
    endfunction

    // Drive one command beat at the falling edge, hold it until taken
    task automatic issue(ppl_pkg::cmd_t c);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        cmds_taken++;
    endtask

    task automatic spawn(int x, int y, int life);
        issue(make_cmd(ppl_pkg::KIND_SPAWN, x, y, life));
    endtask

    // Position and life fields ride along as noise on a tick
    task automatic tick();
        issue(make_cmd(ppl_pkg::KIND_TICK, int'($urandom), int'($urandom), int'($urandom)));
    endtask

    // Hold off until every owed result beat is back and the block is idle
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0 || busy);
    endtask

    // One random stretch: a pool-filling burst, then mixed sequences
    task automatic run_phase(int pct, int quota);
        int stop_at;
        idle_pct = pct;
        stop_at  = cmds_taken + quota;
        repeat (ppl_pkg::POOL_SIZE + 2)
            spawn(int'($urandom), int'($urandom), int'($urandom_range(3)));
        repeat (6)
            tick();
        while (cmds_taken < stop_at)
        begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4:
                begin
                    repeat ($urandom_range(1, 6))
                        spawn(int'($urandom), int'($urandom), short_life());
                    repeat ($urandom_range(1, 3))
                        tick();
                end
                5, 6:
                begin
                    repeat ($urandom_range(2, 5))
                        tick();
                end
                default:
                begin
                    if ($urandom_range(1) == 0)
                        spawn(int'($urandom), int'($urandom), short_life());
                    else
                        tick();
                end
            endcase
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty tick, zero life, position extremes, list unlinking
        idle_pct = 33;
        tick();
        spawn(-32768, 32767, 0);
        tick();
        spawn(32767, -32768, 1);
        spawn(0, 0, 2);
        spawn(21845, -21846, 65535);
        tick();
        wait_drained();
        tick();
        spawn(-1, 1, 0);
        tick();
        tick();
        tick();
        spawn(-21846, 21845, 3);
        spawn(256, -256, 1);
        tick();
        tick();
        wait_drained();

        // Random: sender idles often, then very often, then never
        run_phase(33, 90);
        run_phase(62, 105);
        run_phase(0, 105);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
